// File: hw/rtl/ebbf_pkg.sv
// ============================================================================
// ebbf_pkg: shared definitions for the edge bounding box finder
// Pixel width, configuration register map and reset values.
// ============================================================================
package ebbf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_SIZE_W  = 11;
    localparam int THR_W       = 8;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET     = 11'd1024;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET    = 11'd1024;
    localparam logic [THR_W-1:0]      THRESHOLD_RESET = 8'd30;

endpackage

// File: hw/rtl/edge_bounding_box_finder_unit.sv
// ============================================================================
// edge_bounding_box_finder_unit: bounding box of edge content in a frame
// Scans a raster pixel stream for neighbor differences above a threshold and
// reports the box and the background level once per frame.
// ============================================================================
// Usage:
//   Pixels enter on pixel/pixel_valid/pixel_ready in raster order; a frame is
//   image_width x image_height pixels (clamped to 2..MAX). One result item
//   per frame leaves on result_valid/result_ready with the box fields.
//   Configuration writes use cfg_valid/cfg_index/cfg_data; cfg_ready is
//   always high. Write only between frames or with no pixel in flight.
//   Throughput: one pixel per clock while pixel_ready is high. Each pixel
//   does one read and one write of the line store in its accept cycle; the
//   read data is compared in the following cycle, so the single RAM port
//   carries the full pixel rate. Result path: once the last pixel of a
//   frame is accepted, its box goes from the compare stage into the result
//   hold stage, then the output register, which drives result_valid.
//   Stall: the output register and the result hold stage give two result
//   slots; pixel_ready drops only when both are full and a third frame end
//   reaches the compare stage.
//   Reset: counters, bounds and configuration return to defaults; the line
//   store is not cleared, its first row of each frame is never compared.
// ============================================================================
module edge_bounding_box_finder_unit #(
    parameter int MAX_WIDTH  = ebbf_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ebbf_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ebbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ebbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [ebbf_pkg::PIXEL_W-1:0]     pixel,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             crop_ok,
    output logic [9:0]                       box_left,
    output logic [9:0]                       box_top,
    output logic [10:0]                      box_width,
    output logic [10:0]                      box_height,
    output logic [ebbf_pkg::PIXEL_W-1:0]     background_level
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = ebbf_pkg::PIXEL_W;
    localparam int LEFT_RST = (int'(ebbf_pkg::WIDTH_RESET) > MAX_WIDTH) ?
                              MAX_WIDTH : int'(ebbf_pkg::WIDTH_RESET);
    localparam int TOP_RST  = (int'(ebbf_pkg::HEIGHT_RESET) > MAX_HEIGHT) ?
                              MAX_HEIGHT : int'(ebbf_pkg::HEIGHT_RESET);

    function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic [ebbf_pkg::CFG_SIZE_W-1:0] cfg_width_reg, cfg_height_reg;
    logic [ebbf_pkg::THR_W-1:0]      cfg_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= ebbf_pkg::WIDTH_RESET;
            cfg_height_reg <= ebbf_pkg::HEIGHT_RESET;
            cfg_thr_reg    <= ebbf_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ebbf_pkg::REG_IMAGE_WIDTH:    cfg_width_reg  <= cfg_data;
                ebbf_pkg::REG_IMAGE_HEIGHT:   cfg_height_reg <= cfg_data;
                ebbf_pkg::REG_EDGE_THRESHOLD: cfg_thr_reg    <= cfg_data[ebbf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (cfg_width_reg < 11'd2)
            w_eff = WW'(2);
        else if (32'(cfg_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg_width_reg);
        if (cfg_height_reg < 11'd2)
            h_eff = HW'(2);
        else if (32'(cfg_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg_height_reg);
    end

    // ---------------- accept stage: counters, horizontal edge, RAM access
    logic [CW-1:0] col_reg, col_next, col_now;
    logic [RW-1:0] row_reg, row_next, row_now;
    logic [PW-1:0] prev_reg;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          row_end, frame_end, h_edge, accept;
    logic          s1_hold;

    assign accept      = pixel_valid && pixel_ready;
    assign pixel_ready = !s1_hold;

    always_comb
    begin
        col_now   = (WW'(col_reg) >= w_eff) ? '0 : col_reg;
        row_now   = (HW'(row_reg) >= h_eff) ? '0 : row_reg;
        col_inc   = WW'(col_now) + WW'(1);
        row_inc   = HW'(row_now) + HW'(1);
        row_end   = (col_inc >= w_eff);
        frame_end = row_end && (row_inc >= h_eff);
        h_edge    = (col_now != '0) && (abs_diff(pixel, prev_reg) > cfg_thr_reg);
        col_next  = row_end ? '0 : col_inc[CW-1:0];
        if (!row_end)
            row_next = row_now;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_inc[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            prev_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            prev_reg <= pixel;
        end
    end

    logic [PW-1:0] ls_rdata;

    ebbf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk   (clk),
        .en    (accept),
        .addr  (col_now),
        .wdata (pixel),
        .rdata (ls_rdata)
    );

    // ---------------- compare stage: vertical edge, bound update
    logic          s1_valid_reg;
    logic [PW-1:0] s1_pixel_reg, s1_prev_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_h_edge_reg, s1_row_end_reg, s1_frame_end_reg;
    logic [WW-1:0] s1_w_reg;
    logic [HW-1:0] s1_h_reg;
    logic [ebbf_pkg::THR_W-1:0] s1_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (!s1_hold)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg     <= pixel;
            s1_prev_reg      <= prev_reg;
            s1_col_reg       <= col_now;
            s1_row_reg       <= row_now;
            s1_h_edge_reg    <= h_edge;
            s1_row_end_reg   <= row_end;
            s1_frame_end_reg <= frame_end;
            s1_w_reg         <= w_eff;
            s1_h_reg         <= h_eff;
            s1_thr_reg       <= cfg_thr_reg;
        end
    end

    logic [WW-1:0] left_reg, left_next, left_upd;
    logic [CW-1:0] right_reg, right_next, right_upd;
    logic [HW-1:0] top_reg, top_next, top_upd;
    logic [RW-1:0] bottom_reg, bottom_next, bottom_upd;
    logic [PW-1:0] bg_reg, bg_next, bg_upd;
    logic          row_seen_reg, row_seen_next;
    logic          v_edge, s1_fire;
    logic          fin_valid_reg, fin_move;
    logic [CW-1:0] col_dec;
    logic [RW-1:0] row_dec;

    assign fin_move = fin_valid_reg && (!result_valid || result_ready);
    // hold a frame end here while both result slots are occupied
    assign s1_hold  = s1_valid_reg && s1_frame_end_reg && fin_valid_reg && !fin_move;
    assign s1_fire  = s1_valid_reg && !s1_hold;

    always_comb
    begin
        col_dec    = s1_col_reg - CW'(1);
        row_dec    = s1_row_reg - RW'(1);
        v_edge     = (s1_row_reg != '0) && (abs_diff(s1_pixel_reg, ls_rdata) > s1_thr_reg);
        left_upd   = left_reg;
        right_upd  = right_reg;
        top_upd    = top_reg;
        bottom_upd = bottom_reg;
        bg_upd     = bg_reg;
        row_seen_next = row_seen_reg;
        if (s1_h_edge_reg)
        begin
            if (WW'(s1_col_reg) < left_reg)
                left_upd = WW'(s1_col_reg);
            if (col_dec > right_reg)
                right_upd = col_dec;
            if (!row_seen_reg)
            begin
                bg_upd        = s1_prev_reg;
                row_seen_next = 1'b1;
            end
        end
        if (v_edge)
        begin
            if (HW'(s1_row_reg) < top_reg)
                top_upd = HW'(s1_row_reg);
            if (row_dec > bottom_reg)
                bottom_upd = row_dec;
        end
        if (s1_row_end_reg)
            row_seen_next = 1'b0;
        if (s1_frame_end_reg)
        begin
            left_next   = s1_w_reg;
            right_next  = '0;
            top_next    = s1_h_reg;
            bottom_next = '0;
            bg_next     = '0;
        end
        else
        begin
            left_next   = left_upd;
            right_next  = right_upd;
            top_next    = top_upd;
            bottom_next = bottom_upd;
            bg_next     = bg_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= WW'(LEFT_RST);
            right_reg    <= '0;
            top_reg      <= HW'(TOP_RST);
            bottom_reg   <= '0;
            bg_reg       <= '0;
            row_seen_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            top_reg      <= top_next;
            bottom_reg   <= bottom_next;
            bg_reg       <= bg_next;
            row_seen_reg <= row_seen_next;
        end
    end

    // ---------------- result hold stage
    logic [WW-1:0] fin_left_reg, fin_w_reg;
    logic [CW-1:0] fin_right_reg;
    logic [HW-1:0] fin_top_reg, fin_h_reg;
    logic [RW-1:0] fin_bottom_reg;
    logic [PW-1:0] fin_bg_reg;
    logic          fin_load;

    assign fin_load = s1_fire && s1_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (fin_load)
            fin_valid_reg <= 1'b1;
        else if (fin_move)
            fin_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            fin_left_reg   <= left_upd;
            fin_right_reg  <= right_upd;
            fin_top_reg    <= top_upd;
            fin_bottom_reg <= bottom_upd;
            fin_bg_reg     <= bg_upd;
            fin_w_reg      <= s1_w_reg;
            fin_h_reg      <= s1_h_reg;
        end
    end

    // ---------------- output register
    logic          ok;
    logic [WW-1:0] span_w;
    logic [HW-1:0] span_h;
    logic          out_valid_reg, out_ok_reg;
    logic [9:0]    out_left_reg, out_top_reg;
    logic [10:0]   out_width_reg, out_height_reg;
    logic [PW-1:0] out_bg_reg;

    always_comb
    begin
        ok = (fin_left_reg < fin_w_reg) && (fin_top_reg < fin_h_reg) &&
             (WW'(fin_right_reg) > fin_left_reg) && (HW'(fin_bottom_reg) > fin_top_reg);
        span_w = WW'(fin_right_reg) - fin_left_reg;
        span_h = HW'(fin_bottom_reg) - fin_top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_move)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_move)
        begin
            out_ok_reg     <= ok;
            out_left_reg   <= ok ? 10'(fin_left_reg) : 10'd0;
            out_top_reg    <= ok ? 10'(fin_top_reg) : 10'd0;
            out_width_reg  <= ok ? 11'(span_w) : 11'(fin_w_reg);
            out_height_reg <= ok ? 11'(span_h) : 11'(fin_h_reg);
            out_bg_reg     <= fin_bg_reg;
        end
    end

    assign result_valid     = out_valid_reg;
    assign crop_ok          = out_ok_reg;
    assign box_left         = out_left_reg;
    assign box_top          = out_top_reg;
    assign box_width        = out_width_reg;
    assign box_height       = out_height_reg;
    assign background_level = out_bg_reg;

    // ---------------- assertions
    // consecutive pixels never address the same line store entry
    a_ls_addr_differs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> col_now != s1_col_reg)
        else $error("line store address repeated on consecutive pixels");

    // a frame end also closes its row
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_frame_end_reg |-> s1_row_end_reg)
        else $error("frame end without row end");

    // bounds restart after each frame end
    a_bounds_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_frame_end_reg |=> left_reg == $past(s1_w_reg) &&
            right_reg == '0 && top_reg == $past(s1_h_reg) && bottom_reg == '0)
        else $error("bounds not cleared after frame end");

    // a blocked result in the hold stage keeps its contents
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !fin_move |=> fin_valid_reg && $stable(fin_left_reg) &&
            $stable(fin_top_reg) && $stable(fin_bg_reg))
        else $error("held result changed");

endmodule

// File: hw/rtl/ebbf_line_store.sv
// ============================================================================
// ebbf_line_store: one-row pixel memory
// Single-port synchronous RAM, read-first: a read returns the entry as it
// was before the write issued in the same cycle. Read data holds while idle.
// ============================================================================
module ebbf_line_store #(
    parameter int DEPTH = ebbf_pkg::DEFAULT_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [AW-1:0]                addr,
    input  logic [ebbf_pkg::PIXEL_W-1:0] wdata,
    output logic [ebbf_pkg::PIXEL_W-1:0] rdata
);

    logic [ebbf_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [ebbf_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/ebbf_box_checker.sv
// ============================================================================
// ebbf_box_checker: scoreboard for the edge bounding box finder
// Tracks configuration writes and accepted pixels, predicts the box item of
// every completed frame and compares it field by field with the result items.
// ============================================================================
module ebbf_box_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ebbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ebbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pixel_valid,
    input  logic                             pixel_ready,
    input  logic [ebbf_pkg::PIXEL_W-1:0]     pixel,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic                             crop_ok,
    input  logic [9:0]                       box_left,
    input  logic [9:0]                       box_top,
    input  logic [10:0]                      box_width,
    input  logic [10:0]                      box_height,
    input  logic [ebbf_pkg::PIXEL_W-1:0]     background_level,
    output int                               fail_count,
    output int                               open_boxes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         ok;
        logic [9:0]                   left;
        logic [9:0]                   top;
        logic [10:0]                  width;
        logic [10:0]                  height;
        logic [ebbf_pkg::PIXEL_W-1:0] bg;
    } box_t;

    box_t box_q[$];

    logic [ebbf_pkg::CFG_SIZE_W-1:0] width_reg;
    logic [ebbf_pkg::CFG_SIZE_W-1:0] height_reg;
    logic [ebbf_pkg::THR_W-1:0]      thresh_reg;

    int unsigned                  col_pos;
    int unsigned                  row_pos;
    logic [ebbf_pkg::PIXEL_W-1:0] last_px;
    bit                           edge_in_row;
    logic [ebbf_pkg::PIXEL_W-1:0] row_mem [ebbf_pkg::DEFAULT_MAX_WIDTH];
    int unsigned                  min_left;
    int unsigned                  max_right;
    int unsigned                  min_top;
    int unsigned                  max_bottom;
    logic [ebbf_pkg::PIXEL_W-1:0] bg_pixel;

    function automatic int unsigned clip_dim(logic [ebbf_pkg::CFG_SIZE_W-1:0] raw,
                                             int unsigned hi);
        if (raw < 2)
            return 2;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic bit crosses(logic [ebbf_pkg::PIXEL_W-1:0] a,
                                   logic [ebbf_pkg::PIXEL_W-1:0] b);
        int diff;
        diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return diff > int'(thresh_reg);
    endfunction

    task automatic restart_box();
        min_left   = clip_dim(width_reg, ebbf_pkg::DEFAULT_MAX_WIDTH);
        max_right  = 0;
        min_top    = clip_dim(height_reg, ebbf_pkg::DEFAULT_MAX_HEIGHT);
        max_bottom = 0;
        bg_pixel   = '0;
    endtask

    task automatic scan_pixel(logic [ebbf_pkg::PIXEL_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        box_t        box;
        w = clip_dim(width_reg, ebbf_pkg::DEFAULT_MAX_WIDTH);
        h = clip_dim(height_reg, ebbf_pkg::DEFAULT_MAX_HEIGHT);
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;

        if (c > 0 && crosses(px, last_px))
        begin
            if (c < min_left)
                min_left = c;
            if (c - 1 > max_right)
                max_right = c - 1;
            // background is the pixel left of the first edge in the row
            if (!edge_in_row)
            begin
                bg_pixel    = last_px;
                edge_in_row = 1'b1;
            end
        end
        // the first row of a frame has nothing above it to compare
        if (r > 0 && crosses(px, row_mem[c]))
        begin
            if (r < min_top)
                min_top = r;
            if (r - 1 > max_bottom)
                max_bottom = r - 1;
        end
        row_mem[c] = px;
        last_px    = px;

        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos     = 0;
            edge_in_row = 1'b0;
            row_pos     = r + 1;
            if (row_pos >= h)
            begin
                row_pos = 0;
                if (min_left < w && min_top < h && max_right > min_left && max_bottom > min_top)
                begin
                    box.ok     = 1'b1;
                    box.left   = 10'(min_left);
                    box.top    = 10'(min_top);
                    box.width  = 11'(max_right - min_left);
                    box.height = 11'(max_bottom - min_top);
                end
                else
                begin
                    box.ok     = 1'b0;
                    box.left   = '0;
                    box.top    = '0;
                    box.width  = 11'(w);
                    box.height = 11'(h);
                end
                box.bg = bg_pixel;
                box_q.insert(box_q.size(), box);
                restart_box();
            end
        end
    endtask

    task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        box_t want;
        if (!rst_n)
        begin
            width_reg   = ebbf_pkg::WIDTH_RESET;
            height_reg  = ebbf_pkg::HEIGHT_RESET;
            thresh_reg  = ebbf_pkg::THRESHOLD_RESET;
            col_pos     = 0;
            row_pos     = 0;
            last_px     = '0;
            edge_in_row = 1'b0;
            foreach (row_mem[i])
                row_mem[i] = '0;
            restart_box();
            box_q.delete();
            fail_count  = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (box_q.size() == 0)
                begin
                    $error("result item with no completed frame waiting");
                    fail_count++;
                end
                else
                begin
                    want = box_q.pop_front();
                    check_field("crop_ok", want.ok, crop_ok);
                    check_field("box_left", want.left, box_left);
                    check_field("box_top", want.top, box_top);
                    check_field("box_width", want.width, box_width);
                    check_field("box_height", want.height, box_height);
                    check_field("background_level", want.bg, background_level);
                end
            end
            // a pixel taken at the same edge as a write still sees the old values
            if (pixel_valid && pixel_ready)
                scan_pixel(pixel);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ebbf_pkg::REG_IMAGE_WIDTH:    width_reg  = cfg_data;
                    ebbf_pkg::REG_IMAGE_HEIGHT:   height_reg = cfg_data;
                    ebbf_pkg::REG_EDGE_THRESHOLD: thresh_reg = cfg_data[ebbf_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
        open_boxes = box_q.size();
    end

endmodule

// File: tb/tb_edge_bounding_box_finder_unit.sv
// ============================================================================
// tb_edge_bounding_box_finder_unit: frame level test of the box finder
// Streams directed and random frames under many size and threshold settings
// with random gaps on both channels; the checker scores every result item.
// ============================================================================
module tb_edge_bounding_box_finder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD   = 5;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
    localparam int unsigned RANDOM_PIXELS = 1300;
    localparam int unsigned RANDOM_FRAMES = 40;

    // index past the end of the register map; writes to it must be dropped
    localparam logic [ebbf_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        SCENE_FLAT,
        SCENE_BOX,
        SCENE_SPECKLE,
        SCENE_NOISE
    } scene_kind_t;

    typedef struct {
        scene_kind_t                  kind;
        logic [ebbf_pkg::PIXEL_W-1:0] back;
        logic [ebbf_pkg::PIXEL_W-1:0] fore;
        int unsigned                  r0;
        int unsigned                  r1;
        int unsigned                  c0;
        int unsigned                  c1;
        int unsigned                  jitter;
    } scene_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ebbf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ebbf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             pixel_valid;
    logic                             pixel_ready;
    logic [ebbf_pkg::PIXEL_W-1:0]     pixel;
    logic                             result_valid;
    logic                             result_ready;
    logic                             crop_ok;
    logic [9:0]                       box_left;
    logic [9:0]                       box_top;
    logic [10:0]                      box_width;
    logic [10:0]                      box_height;
    logic [ebbf_pkg::PIXEL_W-1:0]     background_level;

    int fail_count;
    int open_boxes;
    bit pixel_rush = 1'b0;
    bit sink_rush  = 1'b0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    edge_bounding_box_finder_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_valid      (pixel_valid),
        .pixel_ready      (pixel_ready),
        .pixel            (pixel),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .crop_ok          (crop_ok),
        .box_left         (box_left),
        .box_top          (box_top),
        .box_width        (box_width),
        .box_height       (box_height),
        .background_level (background_level)
    );

    ebbf_box_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_valid      (pixel_valid),
        .pixel_ready      (pixel_ready),
        .pixel            (pixel),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .crop_ok          (crop_ok),
        .box_left         (box_left),
        .box_top          (box_top),
        .box_width        (box_width),
        .box_height       (box_height),
        .background_level (background_level),
        .fail_count       (fail_count),
        .open_boxes       (open_boxes)
    );

    function automatic int unsigned frame_dim(logic [ebbf_pkg::CFG_SIZE_W-1:0] raw,
                                              int unsigned hi);
        if (raw < 2)
            return 2;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic scene_t make_scene(int unsigned w, int unsigned h);
        scene_t      s;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            s.kind = SCENE_BOX;
        else if (pick < 14)
            s.kind = SCENE_SPECKLE;
        else if (pick < 17)
            s.kind = SCENE_NOISE;
        else
            s.kind = SCENE_FLAT;
        s.back   = 8'($urandom);
        s.fore   = 8'($urandom);
        s.c0     = $urandom_range(0, w - 1);
        s.c1     = $urandom_range(s.c0, w - 1);
        s.r0     = $urandom_range(0, h - 1);
        s.r1     = $urandom_range(s.r0, h - 1);
        s.jitter = $urandom_range(1, 8);
        return s;
    endfunction

    function automatic logic [ebbf_pkg::PIXEL_W-1:0] pixel_of(scene_t s, int unsigned r,
                                                              int unsigned c);
        int level;
        if (s.kind == SCENE_NOISE)
            return 8'($urandom);
        level = s.back;
        if (s.kind != SCENE_FLAT && r >= s.r0 && r <= s.r1 && c >= s.c0 && c <= s.c1)
            level = s.fore;
        if (s.kind == SCENE_SPECKLE)
        begin
            level = level + int'($urandom_range(0, 2 * s.jitter)) - int'(s.jitter);
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
        end
        return 8'(level);
    endfunction

    task automatic send_pixel(input logic [ebbf_pkg::PIXEL_W-1:0] value);
        int unsigned gap;
        gap = pixel_rush ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= value;
        do
            @(posedge clk);
        while (pixel_ready !== 1'b1);
    endtask

    task automatic send_frame(int unsigned w, int unsigned h, scene_t s);
        if ($urandom_range(0, 3) == 0)
            pixel_rush = !pixel_rush;
        for (int unsigned r = 0; r < h; r++)
        begin
            for (int unsigned c = 0; c < w; c++)
                send_pixel(pixel_of(s, r, c));
        end
    endtask

    // drop valid, let every frame report, then give the pipeline time to empty
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        do
            @(negedge clk);
        while (open_boxes != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ebbf_pkg::CFG_INDEX_W-1:0] index,
                             logic [ebbf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
    endtask

    task automatic set_regs(logic [ebbf_pkg::CFG_DATA_W-1:0] w_raw,
                            logic [ebbf_pkg::CFG_DATA_W-1:0] h_raw,
                            logic [ebbf_pkg::CFG_DATA_W-1:0] thr_raw, bit poke_spare);
        wait_idle();
        write_reg(ebbf_pkg::REG_IMAGE_WIDTH, w_raw);
        write_reg(ebbf_pkg::REG_IMAGE_HEIGHT, h_raw);
        write_reg(ebbf_pkg::REG_EDGE_THRESHOLD, thr_raw);
        if (poke_spare)
            write_reg(REG_SPARE, 11'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned           stall;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
                sink_rush = !sink_rush;
            stall = sink_rush ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        scene_t                          s;
        logic [ebbf_pkg::CFG_DATA_W-1:0] w_raw;
        logic [ebbf_pkg::CFG_DATA_W-1:0] h_raw;
        logic [ebbf_pkg::CFG_DATA_W-1:0] thr_raw;
        int unsigned                     w;
        int unsigned                     h;
        int unsigned                     frames;
        int unsigned                     random_px;
        int unsigned                     frames_done;

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2 after clamping; threshold 255 can never be exceeded
        set_regs(11'd0, 11'd1, 11'h7ff, 1'b1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // threshold 0: a step of one is an edge, but the box collapses
        set_regs(11'd1, 11'd0, 11'd0, 1'b0);
        send_pixel(8'd7);
        send_pixel(8'd7);
        send_pixel(8'd7);
        send_pixel(8'd8);

        // a bright 2x2 block centered in a 4x4 frame gives a real box
        set_regs(11'd4, 11'd4, 11'd30, 1'b0);
        s = '{kind: SCENE_BOX, back: 8'd10, fore: 8'd200, r0: 1, r1: 2, c0: 1, c1: 2,
              jitter: 0};
        send_frame(4, 4, s);

        random_px   = 0;
        frames_done = 0;
        while (random_px < RANDOM_PIXELS || frames_done < RANDOM_FRAMES)
        begin
            case ($urandom_range(0, 9))
                0:       w_raw = 11'($urandom_range(0, 1));
                1:       w_raw = 11'($urandom_range(11, 32));
                default: w_raw = 11'($urandom_range(2, 10));
            endcase
            case ($urandom_range(0, 9))
                0:       h_raw = 11'($urandom_range(0, 1));
                1:       h_raw = 11'($urandom_range(9, 16));
                default: h_raw = 11'($urandom_range(2, 8));
            endcase
            // upper data bits ride along and must be ignored by the threshold
            case ($urandom_range(0, 7))
                0:       thr_raw = {3'($urandom), 8'd0};
                1:       thr_raw = {3'($urandom), 8'd255};
                default: thr_raw = {3'($urandom), 8'($urandom_range(0, 90))};
            endcase
            set_regs(w_raw, h_raw, thr_raw, $urandom_range(0, 3) == 0);
            w      = frame_dim(w_raw, ebbf_pkg::DEFAULT_MAX_WIDTH);
            h      = frame_dim(h_raw, ebbf_pkg::DEFAULT_MAX_HEIGHT);
            frames = $urandom_range(1, 5);
            repeat (frames)
            begin
                send_frame(w, h, make_scene(w, h));
                random_px   += w * h;
                frames_done += 1;
            end
        end

        wait_idle();
        @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ebbf_pkg.sv
hw/rtl/ebbf_line_store.sv
hw/rtl/edge_bounding_box_finder_unit.sv
tb/ebbf_box_checker.sv
tb/tb_edge_bounding_box_finder_unit.sv
